### rtl/core/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Types, constants and helper functions for the euler angle to rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package erm_pkg;

	localparam int AngleW = 16;
	localparam int FieldW = 16;
	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int TrigW = 23;
	localparam int PairW = 2 * TrigW;
	localparam int SumW = 64;
	localparam int AtanEntries = 24;
	localparam int AtanW = 30;

	localparam logic signed [XW-1:0] InvGainQ30 = XW'(652032874);
	localparam logic signed [ZW-1:0] PiQ28 = ZW'(843314857);
	localparam logic signed [ZW-1:0] HalfPiQ28 = ZW'(421657428);
	localparam logic signed [FieldW-1:0] OneQ14 = FieldW'(16384);

	typedef struct packed {
		logic signed [AngleW-1:0] angle_about_x;
		logic signed [AngleW-1:0] angle_about_y;
		logic signed [AngleW-1:0] angle_about_z;
	} angles_t;

	typedef struct packed {
		logic signed [FieldW-1:0] col0_x;
		logic signed [FieldW-1:0] col0_y;
		logic signed [FieldW-1:0] col0_z;
		logic signed [FieldW-1:0] col1_x;
		logic signed [FieldW-1:0] col1_y;
		logic signed [FieldW-1:0] col1_z;
		logic signed [FieldW-1:0] col2_x;
		logic signed [FieldW-1:0] col2_y;
		logic signed [FieldW-1:0] col2_z;
	} matrix_t;

	// atan(2^-i) in Q.28
	function automatic logic [AtanW-1:0] atan_q28(input logic [4:0] i);
		logic [AtanW-1:0] r;
		case (i)
			5'd0: r = AtanW'(210828714);
			5'd1: r = AtanW'(124459457);
			5'd2: r = AtanW'(65760959);
			5'd3: r = AtanW'(33381290);
			5'd4: r = AtanW'(16755422);
			5'd5: r = AtanW'(8385879);
			5'd6: r = AtanW'(4193963);
			5'd7: r = AtanW'(2097109);
			5'd8: r = AtanW'(1048571);
			5'd9: r = AtanW'(524287);
			5'd10: r = AtanW'(262144);
			5'd11: r = AtanW'(131072);
			5'd12: r = AtanW'(65536);
			5'd13: r = AtanW'(32768);
			5'd14: r = AtanW'(16384);
			5'd15: r = AtanW'(8192);
			5'd16: r = AtanW'(4096);
			5'd17: r = AtanW'(2048);
			5'd18: r = AtanW'(1024);
			5'd19: r = AtanW'(512);
			5'd20: r = AtanW'(256);
			5'd21: r = AtanW'(128);
			5'd22: r = AtanW'(64);
			5'd23: r = AtanW'(32);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q.60 sum to a rounded, clamped Q1.14 field
	function automatic logic signed [FieldW-1:0] to_field(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] t;
		logic signed [FieldW-1:0] r;
		t = (v + (SumW'(1) <<< 45)) >>> 46;
		if (t > SumW'(16384))
			r = OneQ14;
		else if (t < -SumW'(16384))
			r = -OneQ14;
		else
			r = t[FieldW-1:0];
		return r;
	endfunction

endpackage

### rtl/core/erm_sincos.sv
// ----------------------------------------------------------------------------
// erm_sincos
// Pipelined rotation-mode cordic: quadrant fold, one micro-rotation per
// stage, then rounding of sine and cosine to Q.20.
// ----------------------------------------------------------------------------
module erm_sincos #(
	parameter int ITERATIONS = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [erm_pkg::AngleW-1:0]      angle,
	output logic signed [erm_pkg::TrigW-1:0]       sin_v,
	output logic signed [erm_pkg::TrigW-1:0]       cos_v
);

	localparam int N = (ITERATIONS > erm_pkg::AtanEntries) ? erm_pkg::AtanEntries : ITERATIONS;
	localparam int XW = erm_pkg::XW;
	localparam int ZW = erm_pkg::ZW;

	logic signed [XW-1:0] x_s [0:N];
	logic signed [XW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic                 flip_s [0:N];

	logic signed [ZW-1:0] z_in;
	logic signed [XW-1:0] xf;
	logic signed [XW-1:0] yf;
	logic signed [XW-1:0] xr;
	logic signed [XW-1:0] yr;

	assign z_in = ZW'(angle) <<< 15;

	// quadrant fold
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= erm_pkg::InvGainQ30;
			y_s[0] <= '0;
			if (z_in > erm_pkg::HalfPiQ28) begin
				z_s[0]    <= z_in - erm_pkg::PiQ28;
				flip_s[0] <= 1'b1;
			end else if (z_in < -erm_pkg::HalfPiQ28) begin
				z_s[0]    <= z_in + erm_pkg::PiQ28;
				flip_s[0] <= 1'b1;
			end else begin
				z_s[0]    <= z_in;
				flip_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [ZW-1:0] atan_c;
		assign atan_c = ZW'(erm_pkg::atan_q28(5'(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_c;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_c;
				end
			end
		end
	end

	assign xf = flip_s[N] ? -x_s[N] : x_s[N];
	assign yf = flip_s[N] ? -y_s[N] : y_s[N];
	assign xr = xf + XW'(512);
	assign yr = yf + XW'(512);

	always_ff @(posedge clk) begin
		if (en) begin
			cos_v <= xr[erm_pkg::TrigW+9:10];
			sin_v <= yr[erm_pkg::TrigW+9:10];
		end
	end

endmodule

### rtl/core/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// ZYX euler angles (Q3.13 radians) to a 3x3 rotation matrix (Q1.14).
//
// angle channel: angle_valid / angle_stall / angles carry one angle triple
// per item. matrix channel: matrix_valid / matrix_stall / matrix carry the
// nine entries of one matrix per item, each rounded and clamped to +-1.
// One item may enter every cycle while angle_stall is low. The pipeline is
// one fold stage, one cordic stage per iteration, one rounding stage, then
// pair products, triple products split in two partial products, and the
// final sum, round and clamp stage that is the output register.
// The whole pipeline advances together; while the output item is held by
// matrix_stall every stage holds and angle_stall is raised, so nothing is
// lost or repeated. Reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
	parameter int SINCOS_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_valid,
	output logic               angle_stall,
	input  erm_pkg::angles_t   angles,
	output logic               matrix_valid,
	input  logic               matrix_stall,
	output erm_pkg::matrix_t   matrix
);

	localparam int N = (SINCOS_ITERATIONS > erm_pkg::AtanEntries) ?
		erm_pkg::AtanEntries : SINCOS_ITERATIONS;
	localparam int Lat = N + 5;
	localparam int TW = erm_pkg::TrigW;
	localparam int PW = erm_pkg::PairW;
	localparam int SW = erm_pkg::SumW;

	logic en;
	logic vld_q [0:Lat-1];

	logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

	assign en = !matrix_valid || !matrix_stall;
	assign angle_stall = !en;
	assign matrix_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Lat; k++)
				vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= angle_valid;
			for (int k = 1; k < Lat; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	erm_sincos #(.ITERATIONS(N)) u_x (
		.clk(clk), .en(en), .angle(angles.angle_about_x), .sin_v(sx), .cos_v(cx));
	erm_sincos #(.ITERATIONS(N)) u_y (
		.clk(clk), .en(en), .angle(angles.angle_about_y), .sin_v(sy), .cos_v(cy));
	erm_sincos #(.ITERATIONS(N)) u_z (
		.clk(clk), .en(en), .angle(angles.angle_about_z), .sin_v(sz), .cos_v(cz));

	// pair products, Q.40
	logic signed [PW-1:0] czcy_s1, szcx_s1, szsx_s1, szcy_s1, czcx_s1, czsx_s1;
	logic signed [PW-1:0] cysx_s1, cycx_s1, sysx_s1, sycx_s1;
	logic signed [TW-1:0] cz_s1, sz_s1, sy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s1 <= PW'(cz) * PW'(cy);
			szcx_s1 <= PW'(sz) * PW'(cx);
			szsx_s1 <= PW'(sz) * PW'(sx);
			szcy_s1 <= PW'(sz) * PW'(cy);
			czcx_s1 <= PW'(cz) * PW'(cx);
			czsx_s1 <= PW'(cz) * PW'(sx);
			cysx_s1 <= PW'(cy) * PW'(sx);
			cycx_s1 <= PW'(cy) * PW'(cx);
			sysx_s1 <= PW'(sy) * PW'(sx);
			sycx_s1 <= PW'(sy) * PW'(cx);
			cz_s1   <= cz;
			sz_s1   <= sz;
			sy_s1   <= sy;
		end
	end

	// triple products as high and low partial products
	localparam int HW = PW - TW;
	localparam int LW = TW + 1;
	localparam int PPW = TW + LW;

	logic signed [HW-1:0] sysx_hi, sycx_hi;
	logic signed [LW-1:0] sysx_lo, sycx_lo;

	assign sysx_hi = sysx_s1[PW-1:TW];
	assign sycx_hi = sycx_s1[PW-1:TW];
	assign sysx_lo = {1'b0, sysx_s1[TW-1:0]};
	assign sycx_lo = {1'b0, sycx_s1[TW-1:0]};

	logic signed [PPW-1:0] czsysx_h_s2, czsysx_l_s2, szsysx_h_s2, szsysx_l_s2;
	logic signed [PPW-1:0] czsycx_h_s2, czsycx_l_s2, szsycx_h_s2, szsycx_l_s2;
	logic signed [PW-1:0]  czcy_s2, szcx_s2, szsx_s2, szcy_s2, czcx_s2, czsx_s2;
	logic signed [PW-1:0]  cysx_s2, cycx_s2;
	logic signed [TW-1:0]  sy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			czsysx_h_s2 <= PPW'(cz_s1) * PPW'(sysx_hi);
			czsysx_l_s2 <= PPW'(cz_s1) * PPW'(sysx_lo);
			szsysx_h_s2 <= PPW'(sz_s1) * PPW'(sysx_hi);
			szsysx_l_s2 <= PPW'(sz_s1) * PPW'(sysx_lo);
			czsycx_h_s2 <= PPW'(cz_s1) * PPW'(sycx_hi);
			czsycx_l_s2 <= PPW'(cz_s1) * PPW'(sycx_lo);
			szsycx_h_s2 <= PPW'(sz_s1) * PPW'(sycx_hi);
			szsycx_l_s2 <= PPW'(sz_s1) * PPW'(sycx_lo);
			czcy_s2 <= czcy_s1;
			szcx_s2 <= szcx_s1;
			szsx_s2 <= szsx_s1;
			szcy_s2 <= szcy_s1;
			czcx_s2 <= czcx_s1;
			czsx_s2 <= czsx_s1;
			cysx_s2 <= cysx_s1;
			cycx_s2 <= cycx_s1;
			sy_s2   <= sy_s1;
		end
	end

	// sums in Q.60
	logic signed [SW-1:0] t_czsysx, t_szsysx, t_czsycx, t_szsycx;
	logic signed [SW-1:0] up_czcy, up_szcx, up_szsx, up_szcy, up_czcx, up_czsx;
	logic signed [SW-1:0] up_cysx, up_cycx, up_nsy;

	assign t_czsysx = (SW'(czsysx_h_s2) <<< TW) + SW'(czsysx_l_s2);
	assign t_szsysx = (SW'(szsysx_h_s2) <<< TW) + SW'(szsysx_l_s2);
	assign t_czsycx = (SW'(czsycx_h_s2) <<< TW) + SW'(czsycx_l_s2);
	assign t_szsycx = (SW'(szsycx_h_s2) <<< TW) + SW'(szsycx_l_s2);
	assign up_czcy = SW'(czcy_s2) <<< 20;
	assign up_szcx = SW'(szcx_s2) <<< 20;
	assign up_szsx = SW'(szsx_s2) <<< 20;
	assign up_szcy = SW'(szcy_s2) <<< 20;
	assign up_czcx = SW'(czcx_s2) <<< 20;
	assign up_czsx = SW'(czsx_s2) <<< 20;
	assign up_cysx = SW'(cysx_s2) <<< 20;
	assign up_cycx = SW'(cycx_s2) <<< 20;
	assign up_nsy  = -(SW'(sy_s2) <<< 40);

	always_ff @(posedge clk) begin
		if (en) begin
			matrix.col0_x <= erm_pkg::to_field(up_czcy);
			matrix.col0_y <= erm_pkg::to_field(t_czsysx - up_szcx);
			matrix.col0_z <= erm_pkg::to_field(up_szsx + t_czsycx);
			matrix.col1_x <= erm_pkg::to_field(up_szcy);
			matrix.col1_y <= erm_pkg::to_field(up_czcx + t_szsysx);
			matrix.col1_z <= erm_pkg::to_field(t_szsycx - up_czsx);
			matrix.col2_x <= erm_pkg::to_field(up_nsy);
			matrix.col2_y <= erm_pkg::to_field(up_cysx);
			matrix.col2_z <= erm_pkg::to_field(up_cycx);
		end
	end

endmodule
